/* rtl/tdpt_pkg.sv */
`default_nettype none

package tdpt_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture a new word, set divisor to two
		logic start_div;  // clear remainder, reload dividend shifter
		logic step;       // one restoring-division bit
		logic next_div;   // advance divisor and its square
	} tdpt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic below_two;  // number is zero or one
		logic sq_le_n;    // divisor squared still within the number
		logic rem_zero;   // remainder of the last division is zero
	} tdpt_stat_t;

endpackage

`default_nettype wire

/* rtl/tdpt_dp.sv */
`default_nettype none

module tdpt_dp #(
	parameter int NUM_WIDTH = 27
) (
	input  wire                       clk,
	input  wire  tdpt_pkg::tdpt_cmd_t cmd,
	input  wire  [NUM_WIDTH-1:0]      number,
	output logic [NUM_WIDTH-1:0]      tested_value,
	output tdpt_pkg::tdpt_stat_t      stat
);
	import tdpt_pkg::*;

	localparam logic [NUM_WIDTH-1:0] FirstDiv = NUM_WIDTH'(2);
	localparam logic [NUM_WIDTH:0]   FirstSq  = (NUM_WIDTH + 1)'(4);

	logic [NUM_WIDTH-1:0] num_q;
	logic [NUM_WIDTH-1:0] div_q;
	logic [NUM_WIDTH:0]   sq_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [NUM_WIDTH-1:0] shreg_q;

	logic [NUM_WIDTH:0]   rem_ext;
	logic [NUM_WIDTH:0]   rem_sub;
	logic [NUM_WIDTH-1:0] rem_next;

	// one restoring-division bit: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_ext  = {rem_q, shreg_q[NUM_WIDTH-1]};
		rem_sub  = rem_ext - {1'b0, div_q};
		if (rem_ext >= {1'b0, div_q}) begin
			rem_next = rem_sub[NUM_WIDTH-1:0];
		end else begin
			rem_next = rem_ext[NUM_WIDTH-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= number;
			div_q <= FirstDiv;
			sq_q  <= FirstSq;
		end else if (cmd.next_div) begin
			// (d+1)^2 = d^2 + 2d + 1
			sq_q  <= sq_q + {div_q, 1'b1};
			div_q <= div_q + NUM_WIDTH'(1);
		end

		if (cmd.start_div) begin
			rem_q   <= '0;
			shreg_q <= num_q;
		end else if (cmd.step) begin
			rem_q   <= rem_next;
			shreg_q <= {shreg_q[NUM_WIDTH-2:0], 1'b0};
		end
	end

	assign tested_value   = num_q;
	assign stat.below_two = (num_q[NUM_WIDTH-1:1] == '0);
	assign stat.sq_le_n   = (sq_q <= {1'b0, num_q});
	assign stat.rem_zero  = (rem_q == '0);

endmodule

`default_nettype wire

/* rtl/tdpt_ctrl.sv */
`default_nettype none

module tdpt_ctrl #(
	parameter int NUM_WIDTH = 27
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire  tdpt_pkg::tdpt_stat_t stat,
	output tdpt_pkg::tdpt_cmd_t        cmd,
	output logic                       busy,
	output logic                       done,
	output logic                       is_prime
);
	import tdpt_pkg::*;

	localparam int CntW = (NUM_WIDTH > 2) ? $clog2(NUM_WIDTH) : 1;
	localparam logic [CntW-1:0] LastBit = CntW'(NUM_WIDTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_TEST,
		ST_REPORT
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            prime_q;

	// commands follow the current state
	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && start;
		cmd.start_div = (state_q == ST_CHECK) && !stat.below_two && stat.sq_le_n;
		cmd.step      = (state_q == ST_DIVIDE);
		cmd.next_div  = (state_q == ST_TEST) && !stat.rem_zero;
	end

	// sequencer: check bound, divide bit by bit, test remainder, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (stat.below_two) begin
						prime_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_REPORT;
					end else if (!stat.sq_le_n) begin
						prime_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_REPORT;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					cnt_q <= cnt_q + CntW'(1);
					if (cnt_q == LastBit) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (stat.rem_zero) begin
						prime_q <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_REPORT;
					end else begin
						state_q <= ST_CHECK;
					end
				end
				ST_REPORT: begin
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign is_prime = prime_q;

endmodule

`default_nettype wire

/* rtl/trial_division_prime_test.sv */
`default_nettype none

// Primality test by trial division. A word is taken when start is high and
// busy is low; busy stays high until the result has been shown. The result
// (tested_value, is_prime) is valid for exactly one cycle while done is high,
// and the receiver must take it then. Zero and one report not prime. Divisors
// 2, 3, ... are tried while d*d <= number, stopping at the first that divides.
// Each divisor passes through the bound check, the bit-serial restoring
// divider and the remainder test. A prime reports after its bound check
// fails, a composite after the remainder test of the first divisor that
// divides, and zero and one after the first bound check. busy falls at the
// edge that ends the done cycle, so the next word can be taken in the cycle
// after.
module trial_division_prime_test #(
	parameter int NUM_WIDTH = 27
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire  [NUM_WIDTH-1:0] number,
	output logic                 done,
	output logic [NUM_WIDTH-1:0] tested_value,
	output logic                 is_prime
);
	import tdpt_pkg::*;

	tdpt_cmd_t  cmd;
	tdpt_stat_t stat;

	tdpt_ctrl #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.is_prime (is_prime)
	);

	tdpt_dp #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.number       (number),
		.tested_value (tested_value),
		.stat         (stat)
	);

endmodule

`default_nettype wire

/* rtl/tdpt_checker.sv */
`default_nettype none

module tdpt_checker #(
	parameter int NUM_WIDTH = 27
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 start,
	input wire                 busy,
	input wire [NUM_WIDTH-1:0] number,
	input wire                 done,
	input wire [NUM_WIDTH-1:0] tested_value,
	input wire                 is_prime
);

	// a result only comes while a word is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without a word in flight");

	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// one result per word
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// zero and one are never prime
	a_small_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		done && (tested_value[NUM_WIDTH-1:1] == '0) |-> !is_prime)
		else $error("zero or one reported prime");

	// the echoed word is the one accepted
	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |=> tested_value == $past(number, 2))
		else $error("echoed word differs from accepted word");

endmodule

bind trial_division_prime_test tdpt_checker #(
	.NUM_WIDTH (NUM_WIDTH)
) u_tdpt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.number       (number),
	.done         (done),
	.tested_value (tested_value),
	.is_prime     (is_prime)
);

`default_nettype wire
